@@ sv/utf8cc_pkg.sv @@
// package: field widths and byte class constants for the utf-8 character counter
`timescale 1ns / 1ps
package utf8cc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 16;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [COUNT_W-1:0] t_count;

    // lead byte bounds
    localparam t_byte LEAD_MIN   = 8'hC2;
    localparam t_byte LEAD_END   = 8'hF5;
    localparam t_byte LEAD3_MIN  = 8'hE0;
    localparam t_byte LEAD4_MIN  = 8'hF0;
    // continuation byte range
    localparam t_byte CONT_MIN   = 8'h80;
    localparam t_byte CONT_END   = 8'hC0;
    // leads with a narrowed second byte
    localparam t_byte LEAD_E0    = 8'hE0;
    localparam t_byte LEAD_ED    = 8'hED;
    localparam t_byte LEAD_F0    = 8'hF0;
    localparam t_byte LEAD_F4    = 8'hF4;
    localparam t_byte CONT_A0    = 8'hA0;
    localparam t_byte CONT_90    = 8'h90;

endpackage

@@ sv/utf8cc_ifs.sv @@
// interfaces: byte input channel and count result channel
`timescale 1ns / 1ps
interface utf8cc_byte_if;
    logic                 valid;
    logic                 ready;
    utf8cc_pkg::t_byte    data_byte;
    logic                 last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8cc_count_if;
    logic                 valid;
    logic                 ready;
    utf8cc_pkg::t_count   char_count;

    modport source (output valid, output char_count, input ready);
    modport sink   (input valid, input char_count, output ready);
endinterface

@@ sv/utf8_character_counter.sv @@
// top level: validating utf-8 character counter over a byte stream
//
// i_in carries one byte per transfer with last_byte marking the final byte
// of a buffer. o_out carries one count per buffer, sent after the last byte.
// well-formed utf-8 sequences count as one character; every byte of a broken,
// overlong, surrogate, out-of-range or truncated sequence counts on its own.
// the count saturates at 2^COUNT_BITS-1 and is shown in 16 bits.
// one byte is taken every cycle except while a last byte waits for o_out. a
// byte is captured in the input register, then the decode stage updates the
// held sequence and the count; for a last byte the count lands in the output
// register, which raises o_out.valid.
// when o_out is stalled, bytes without the last mark keep flowing; a last
// byte waits in the input register until the output register frees up.
// reset clears the held sequence, the count and both valid flags.
`timescale 1ns / 1ps
module utf8_character_counter #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    utf8cc_byte_if.sink           i_in,
    utf8cc_count_if.source        o_out
);

    typedef logic [COUNT_BITS-1:0] t_cnt;
    localparam t_cnt CNT_MAX = '1;

    // input register
    logic                 r_s1_valid;
    utf8cc_pkg::t_byte    r_s1_byte;
    logic                 r_s1_last;
    // sequence state
    utf8cc_pkg::t_byte    r_held_lead, n_held_lead;
    logic [1:0]           r_held_bytes, n_held_bytes;
    t_cnt                 r_count, n_count;
    // result register
    logic                 r_out_valid;
    utf8cc_pkg::t_count   r_out_count;

    logic                 w_out_free;
    logic                 w_s1_fire;
    logic [2:0]           w_add;
    logic [2:0]           w_seq_len;
    logic [2:0]           w_held_inc;
    logic                 w_is_lead;
    logic                 w_ok;
    logic [COUNT_BITS:0]  w_sum;
    t_cnt                 w_total;
    logic [31:0]          w_total_ext;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_fire  = r_s1_valid && (!r_s1_last || w_out_free);
    assign i_in.ready = !r_s1_valid || w_s1_fire;

    always_comb begin
        w_is_lead = (r_s1_byte >= utf8cc_pkg::LEAD_MIN) && (r_s1_byte < utf8cc_pkg::LEAD_END);

        if (r_held_lead < utf8cc_pkg::LEAD3_MIN) begin
            w_seq_len = 3'd2;
        end else if (r_held_lead < utf8cc_pkg::LEAD4_MIN) begin
            w_seq_len = 3'd3;
        end else begin
            w_seq_len = 3'd4;
        end
        w_held_inc = {1'b0, r_held_bytes} + 3'd1;

        w_ok = (r_s1_byte >= utf8cc_pkg::CONT_MIN) && (r_s1_byte < utf8cc_pkg::CONT_END);
        // second byte limits for overlong, surrogate and above-range forms
        if (r_held_bytes == 2'd1) begin
            if (r_held_lead == utf8cc_pkg::LEAD_E0 && r_s1_byte < utf8cc_pkg::CONT_A0)
                w_ok = 1'b0;
            if (r_held_lead == utf8cc_pkg::LEAD_ED && r_s1_byte >= utf8cc_pkg::CONT_A0)
                w_ok = 1'b0;
            if (r_held_lead == utf8cc_pkg::LEAD_F0 && r_s1_byte < utf8cc_pkg::CONT_90)
                w_ok = 1'b0;
            if (r_held_lead == utf8cc_pkg::LEAD_F4 && r_s1_byte >= utf8cc_pkg::CONT_90)
                w_ok = 1'b0;
        end

        n_held_lead  = r_held_lead;
        n_held_bytes = r_held_bytes;
        w_add        = 3'd0;

        if (r_held_bytes == 2'd0 || !w_ok) begin
            // held bytes of a broken sequence each count once
            w_add = {1'b0, r_held_bytes};
            if (w_is_lead) begin
                n_held_lead  = r_s1_byte;
                n_held_bytes = 2'd1;
            end else begin
                n_held_lead  = '0;
                n_held_bytes = 2'd0;
                w_add        = w_add + 3'd1;
            end
        end else if (w_held_inc >= w_seq_len) begin
            w_add        = 3'd1;
            n_held_lead  = '0;
            n_held_bytes = 2'd0;
        end else begin
            n_held_bytes = w_held_inc[1:0];
        end

        // truncated sequence at end of buffer
        if (r_s1_last) begin
            w_add        = w_add + {1'b0, n_held_bytes};
            n_held_lead  = '0;
            n_held_bytes = 2'd0;
        end

        w_sum   = {1'b0, r_count} + (COUNT_BITS+1)'(w_add);
        w_total = w_sum[COUNT_BITS] ? CNT_MAX : w_sum[COUNT_BITS-1:0];
        n_count = r_s1_last ? '0 : w_total;
    end

    assign w_total_ext = 32'(w_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_held_lead  <= '0;
            r_held_bytes <= 2'd0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_s1_fire) begin
                r_held_lead  <= n_held_lead;
                r_held_bytes <= n_held_bytes;
                r_count      <= n_count;
            end
            if (w_s1_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_last <= i_in.last_byte;
        end
        if (w_s1_fire && r_s1_last) begin
            r_out_count <= w_total_ext[utf8cc_pkg::COUNT_W-1:0];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.char_count = r_out_count;

`ifndef ASSERT_OFF
    a_held_lead_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_bytes != 2'd0 |->
            (r_held_lead >= utf8cc_pkg::LEAD_MIN && r_held_lead < utf8cc_pkg::LEAD_END))
        else $error("held sequence without a valid lead byte");

    a_idle_lead_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_bytes == 2'd0 |-> r_held_lead == '0)
        else $error("lead byte kept with no sequence pending");

    a_three_held_four_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_bytes == 2'd3 |-> r_held_lead >= utf8cc_pkg::LEAD4_MIN)
        else $error("three bytes held for a short sequence");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && r_s1_last) |=> (r_held_bytes == 2'd0 && r_count == '0 && r_out_valid))
        else $error("end of buffer did not clear state and post a count");
`endif

endmodule

@@ tb/testbench.sv @@
// testbench: random and directed byte streams checked against a utf-8 count predictor
`timescale 1ns / 1ps
module testbench;
    import utf8cc_pkg::*;

    localparam int unsigned COUNT_BITS  = 16;
    localparam int unsigned COUNT_TOP   = (1 << COUNT_BITS) - 1;
    localparam int unsigned RAND_BYTES  = 1750;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_REPORTS = 10;

    localparam t_byte ASCII_MAX = 8'h7F;
    localparam t_byte CONT_MAX  = 8'hBF;
    localparam t_byte LEAD2_MAX = 8'hDF;
    localparam t_byte LEAD3_MAX = 8'hEF;
    localparam t_byte BYTE_MAX  = 8'hFF;

    typedef struct packed {
        t_byte data;
        logic  last;
        logic  quiet;   // no sender gap after this byte
    } t_feed_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    utf8cc_byte_if  in_if();
    utf8cc_count_if out_if();

    utf8_character_counter #(
        .COUNT_BITS(COUNT_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_feed_item  byte_queue[$];
    t_byte       buf_bytes[$];
    t_count      pending_counts[$];
    int unsigned total_items;
    int unsigned bytes_taken;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned gap_left;
    int unsigned stall_left;
    logic        calm;
    t_feed_item  cur_item;
    t_count      want_count;

    // predictor state
    t_byte       seq_lead;
    int unsigned seq_held;
    int unsigned char_tally;

    function automatic void add_chars(int unsigned k);
        if (k > COUNT_TOP - char_tally)
            char_tally = COUNT_TOP;
        else
            char_tally = char_tally + k;
    endfunction

    function automatic void open_char(t_byte b);
        if (b >= LEAD_MIN && b < LEAD_END) begin
            seq_lead = b;
            seq_held = 1;
        end else begin
            add_chars(1);
        end
    endfunction

    function automatic int unsigned seq_length(t_byte lead);
        if (lead < LEAD3_MIN)
            return 2;
        if (lead < LEAD4_MIN)
            return 3;
        return 4;
    endfunction

    function automatic void predict_byte(t_byte b, logic last);
        logic fits;
        if (seq_held == 0) begin
            open_char(b);
        end else begin
            fits = (b >= CONT_MIN && b < CONT_END);
            // narrowed second byte: overlong, surrogate and above-range forms
            if (fits && seq_held == 1) begin
                if (seq_lead == LEAD_E0 && b < CONT_A0)
                    fits = 1'b0;
                if (seq_lead == LEAD_ED && b >= CONT_A0)
                    fits = 1'b0;
                if (seq_lead == LEAD_F0 && b < CONT_90)
                    fits = 1'b0;
                if (seq_lead == LEAD_F4 && b >= CONT_90)
                    fits = 1'b0;
            end
            if (fits) begin
                seq_held = seq_held + 1;
                if (seq_held >= seq_length(seq_lead)) begin
                    add_chars(1);
                    seq_held = 0;
                    seq_lead = '0;
                end
            end else begin
                add_chars(seq_held);
                seq_held = 0;
                seq_lead = '0;
                open_char(b);
            end
        end
        if (last) begin
            // bytes of a sequence cut off by the end count one each
            add_chars(seq_held);
            pending_counts = {pending_counts, t_count'(char_tally[COUNT_W-1:0])};
            seq_held   = 0;
            seq_lead   = '0;
            char_tally = 0;
        end
    endfunction

    function automatic void put_byte(t_byte b);
        buf_bytes = {buf_bytes, b};
    endfunction

    function automatic t_byte rand_byte(t_byte lo, t_byte hi);
        return t_byte'($urandom_range(lo, hi));
    endfunction

    function automatic void push_valid_char(int unsigned len);
        t_byte       lead;
        int unsigned pick;
        pick = $urandom_range(0, 3);
        case (len)
            1: put_byte(rand_byte(8'h00, ASCII_MAX));
            2: begin
                put_byte(rand_byte(LEAD_MIN, LEAD2_MAX));
                put_byte(rand_byte(CONT_MIN, CONT_MAX));
            end
            3: begin
                lead = (pick == 0) ? LEAD_E0 : (pick == 1) ? LEAD_ED
                                             : rand_byte(LEAD3_MIN, LEAD3_MAX);
                put_byte(lead);
                if (lead == LEAD_E0)
                    put_byte(rand_byte(CONT_A0, CONT_MAX));
                else if (lead == LEAD_ED)
                    put_byte(rand_byte(CONT_MIN, t_byte'(CONT_A0 - 1)));
                else
                    put_byte(rand_byte(CONT_MIN, CONT_MAX));
                put_byte(rand_byte(CONT_MIN, CONT_MAX));
            end
            default: begin
                lead = (pick == 0) ? LEAD_F0 : (pick == 1) ? LEAD_F4
                                             : rand_byte(LEAD4_MIN, LEAD_F4);
                put_byte(lead);
                if (lead == LEAD_F0)
                    put_byte(rand_byte(CONT_90, CONT_MAX));
                else if (lead == LEAD_F4)
                    put_byte(rand_byte(CONT_MIN, t_byte'(CONT_90 - 1)));
                else
                    put_byte(rand_byte(CONT_MIN, CONT_MAX));
                put_byte(rand_byte(CONT_MIN, CONT_MAX));
                put_byte(rand_byte(CONT_MIN, CONT_MAX));
            end
        endcase
    endfunction

    // multi-byte prefix of a well-formed character, optionally followed by an extra byte that may break it
    function automatic void push_partial_char(bit add_breaker);
        int unsigned start;
        int unsigned len;
        int unsigned keep;
        t_byte       lead;
        start = buf_bytes.size();
        len   = $urandom_range(2, 4);
        push_valid_char(len);
        keep  = $urandom_range(1, len - 1);
        while (buf_bytes.size() > start + keep)
            void'(buf_bytes.pop_back());
        if (!add_breaker)
            return;
        lead = buf_bytes[start];
        if (keep == 1 && $urandom_range(0, 1) == 1) begin
            // continuation just outside the narrowed range of the lead, or any byte for other leads
            case (lead)
                LEAD_E0: put_byte(rand_byte(CONT_MIN, t_byte'(CONT_A0 - 1)));
                LEAD_ED: put_byte(rand_byte(CONT_A0, CONT_MAX));
                LEAD_F0: put_byte(rand_byte(CONT_MIN, t_byte'(CONT_90 - 1)));
                LEAD_F4: put_byte(rand_byte(CONT_90, CONT_MAX));
                default: put_byte(rand_byte(8'h00, BYTE_MAX));
            endcase
        end else if ($urandom_range(0, 1) == 1) begin
            put_byte(rand_byte(LEAD_MIN, BYTE_MAX));
        end else begin
            put_byte(rand_byte(8'h00, BYTE_MAX));
        end
    endfunction

    function automatic void queue_buffer(logic quiet);
        t_feed_item it;
        foreach (buf_bytes[i]) begin
            it.data  = buf_bytes[i];
            it.last  = (i == buf_bytes.size() - 1);
            it.quiet = quiet;
            byte_queue = {byte_queue, it};
        end
        buf_bytes.delete();
    endfunction

    function automatic void queue_random_buffer();
        int unsigned nchars;
        int unsigned pick;
        nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
        repeat (nchars) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                push_valid_char($urandom_range(1, 4));
            else if (pick < 75)
                push_partial_char(1'b1);
            else if (pick < 92)
                put_byte(rand_byte(8'h00, BYTE_MAX));
            else
                put_byte(8'h00);
        end
        if ($urandom_range(0, 4) == 0)
            push_partial_char(1'b0);
        queue_buffer(1'b0);
    endfunction

    // mostly short gaps, now and then a long one, none in calm stretches
    function automatic int unsigned pick_gap(logic quiet);
        int unsigned pick;
        if (quiet || calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic note_failure(string msg);
        fail_count = fail_count + 1;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (gap_left > 0) begin
                in_if.valid <= 1'b0;
                gap_left = gap_left - 1;
            end else if (byte_queue.size() > 0) begin
                cur_item = byte_queue.pop_front();
                in_if.valid     <= 1'b1;
                in_if.data_byte <= cur_item.data;
                in_if.last_byte <= cur_item.last;
                gap_left = pick_gap(cur_item.quiet);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // input monitor: every byte transfer updates the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            predict_byte(in_if.data_byte, in_if.last_byte);
            bytes_taken <= bytes_taken + 1;
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            out_if.ready <= 1'b1;
            stall_left = pick_gap(1'b0);
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_counts.size() == 0) begin
                note_failure($sformatf("unexpected count %0d", out_if.char_count));
            end else begin
                want_count = pending_counts.pop_front();
                if (out_if.char_count !== want_count)
                    note_failure($sformatf("char_count expected %0d actual %0d",
                                           want_count, out_if.char_count));
            end
        end
    end

    // cycle count, calm stretches and watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if ($urandom_range(0, 299) == 0)
            calm <= ~calm;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = '0;
        in_if.last_byte  = 1'b0;
        out_if.ready     = 1'b0;
        calm             = 1'b0;
        gap_left         = 0;
        stall_left       = 0;
        bytes_taken      = 0;
        fail_count       = 0;
        cycle_count      = 0;
        seq_lead         = '0;
        seq_held         = 0;
        char_tally       = 0;

        // zero, ascii top, two-byte top, overlong, surrogate, below and above range,
        // forbidden leads, stray continuation, four-byte minimum, cut-off tail
        buf_bytes = '{8'h00, ASCII_MAX, LEAD2_MAX, CONT_MAX, LEAD_E0, 8'h9F, LEAD_ED, CONT_A0,
                      LEAD_F0, 8'h8F, LEAD_F4, CONT_90, 8'hC0, 8'hC1, LEAD_END, BYTE_MAX,
                      CONT_MIN, LEAD_F0, CONT_90, CONT_MIN, CONT_MIN, 8'hE2, 8'h82};
        queue_buffer(1'b0);
        // single-byte buffer
        buf_bytes = '{8'h41};
        queue_buffer(1'b0);

        while (byte_queue.size() < RAND_BYTES)
            queue_random_buffer();
        total_items = byte_queue.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != total_items)
            @(posedge i_clk);
        while (pending_counts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
